### src/best_fit_block_allocator_unit_defines.svh
// ----------------------------------------------------------------------------
// best-fit block allocator assertion macros
// shared assertion forms, clocked on clock and disabled while reset is high
// ----------------------------------------------------------------------------
`ifndef BEST_FIT_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH
`define BEST_FIT_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH

// same-cycle implication
`define BFBA_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bfba assertion failed");

// next-cycle implication
`define BFBA_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bfba assertion failed");

`endif

### src/bfba_pkg.sv
// ----------------------------------------------------------------------------
// bfba_pkg
// shared codes and types of the best-fit block allocator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bfba_pkg;

   // request actions
   localparam logic [1:0] ACT_ALLOC    = 2'd0;
   localparam logic [1:0] ACT_FREE     = 2'd1;
   localparam logic [1:0] ACT_FREE_ALL = 2'd2;

   // result status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NO_MEM   = 2'd1;
   localparam logic [1:0] ST_NOT_OWN  = 2'd2;
   localparam logic [1:0] ST_BAD_ADDR = 2'd3;

   // register indexes
   localparam logic [1:0] REG_BASE   = 2'd0;
   localparam logic [1:0] REG_SHIFT  = 2'd1;
   localparam logic [1:0] REG_BLOCKS = 2'd2;

   localparam logic [4:0] MAX_SHIFT = 5'd20;

   // one result item
   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] granted_address;
      logic [31:0] granted_size;
   } rsp_type;

endpackage

`default_nettype wire

### src/bfba_ram.sv
// ----------------------------------------------------------------------------
// bfba_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bfba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

### src/bfba_core.sv
// ----------------------------------------------------------------------------
// bfba_core
// run-head walk sequencer over the block table memory
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bfba_core #(
   parameter int BLOCK_SLOTS = 256,
   parameter int CLIENT_BITS = 8
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic [1:0]                        action,
   input  wire logic [31:0]                       byte_count,
   input  wire logic [31:0]                       region_address,
   input  wire logic [7:0]                        client_id,
   input  wire logic [31:0]                       cfg_base,
   input  wire logic [4:0]                        cfg_shift,
   input  wire logic [$clog2(BLOCK_SLOTS+1)-1:0]  cfg_blocks,
   input  wire logic                              reinit,
   output logic                                   rsp_valid,
   output bfba_pkg::rsp_type                      rsp
);
   import bfba_pkg::*;
   `include "best_fit_block_allocator_unit_defines.svh"

   localparam int AW = $clog2(BLOCK_SLOTS);
   localparam int LW = $clog2(BLOCK_SLOTS + 1);
   localparam int OW = CLIENT_BITS;
   localparam int IW = LW + 1;
   localparam int DW = 2 * LW + OW;

   typedef enum logic [15:0] {
      S_IDLE   = 16'b0000_0000_0000_0001,
      S_CLR    = 16'b0000_0000_0000_0010,
      S_AWALK  = 16'b0000_0000_0000_0100,
      S_AEVAL  = 16'b0000_0000_0000_1000,
      S_AGRANT = 16'b0000_0000_0001_0000,
      S_ASPLIT = 16'b0000_0000_0010_0000,
      S_FHEAD  = 16'b0000_0000_0100_0000,
      S_FCHK   = 16'b0000_0000_1000_0000,
      S_RRD    = 16'b0000_0001_0000_0000,
      S_REV    = 16'b0000_0010_0000_0000,
      S_LRD    = 16'b0000_0100_0000_0000,
      S_LEV    = 16'b0000_1000_0000_0000,
      S_FWRITE = 16'b0001_0000_0000_0000,
      S_GWALK  = 16'b0010_0000_0000_0000,
      S_GEV    = 16'b0100_0000_0000_0000,
      S_DONE   = 16'b1000_0000_0000_0000
   } state_type;

   state_type      state_ff, state_in;
   logic [IW-1:0]  idx_ff, idx_in;
   logic [AW-1:0]  head_ff, head_in;
   logic [AW-1:0]  best_ff, best_in;
   logic [LW-1:0]  best_free_ff, best_free_in;
   logic           found_ff, found_in;
   logic [LW-1:0]  need_ff, need_in;
   logic [LW-1:0]  len_ff, len_in;
   logic [LW-1:0]  fl_ff, fl_in;
   logic           merged_ff, merged_in;
   logic [OW-1:0]  cl_ff, cl_in;
   logic           all_ff, all_in;
   logic [AW:0]    clr_ff, clr_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_type        rsp_ff, rsp_in;

   logic           ram_we;
   logic [AW-1:0]  ram_waddr, ram_raddr;
   logic [DW-1:0]  ram_wdata, ram_rdata;

   logic [LW-1:0]  rd_free, rd_alloc, step;
   logic [OW-1:0]  rd_owner;
   logic [15:0]    client_ext;
   logic [32:0]    round_sum, need_wide;
   logic [31:0]    offset, free_idx;
   logic [IW-1:0]  right_idx, head_ext, n_ext;

   bfba_ram #(.WIDTH(DW), .DEPTH(BLOCK_SLOTS)) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // table word fields and walk step
   assign rd_free  = ram_rdata[DW-1 -: LW];
   assign rd_alloc = ram_rdata[OW +: LW];
   assign rd_owner = ram_rdata[OW-1:0];
   assign step = (rd_free != '0) ? rd_free : ((rd_alloc != '0) ? rd_alloc : LW'(1));

   // request decode
   assign client_ext = {8'd0, client_id};
   assign round_sum  = {1'b0, byte_count} + ((33'd1 << cfg_shift) - 33'd1);
   assign need_wide  = round_sum >> cfg_shift;
   assign offset     = region_address - cfg_base;
   assign free_idx   = offset >> cfg_shift;
   assign head_ext   = IW'(head_ff);
   assign right_idx  = head_ext + IW'(len_ff);
   assign n_ext      = IW'(cfg_blocks);

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      head_in      = head_ff;
      best_in      = best_ff;
      best_free_in = best_free_ff;
      found_in     = found_ff;
      need_in      = need_ff;
      len_in       = len_ff;
      fl_in        = fl_ff;
      merged_in    = merged_ff;
      cl_in        = cl_ff;
      all_in       = all_ff;
      clr_in       = clr_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      ram_we       = 1'b0;
      ram_waddr    = head_ff;
      ram_wdata    = '0;
      ram_raddr    = idx_ff[AW-1:0];

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cl_in  = client_ext[OW-1:0];
               rsp_in = '{status: ST_OK, granted_address: 32'd0, granted_size: 32'd0};
               case (action)
                  ACT_ALLOC: begin
                     if (need_wide == 33'd0 || need_wide > 33'(cfg_blocks)) begin
                        rsp_in.status = ST_NO_MEM;
                        state_in      = S_DONE;
                     end else begin
                        need_in  = LW'(need_wide);
                        idx_in   = '0;
                        found_in = 1'b0;
                        state_in = S_AWALK;
                     end
                  end
                  ACT_FREE: begin
                     if (free_idx >= 32'(cfg_blocks)) begin
                        rsp_in.status = ST_BAD_ADDR;
                        state_in      = S_DONE;
                     end else begin
                        head_in  = free_idx[AW-1:0];
                        all_in   = 1'b0;
                        state_in = S_FHEAD;
                     end
                  end
                  ACT_FREE_ALL: begin
                     all_in   = 1'b1;
                     idx_in   = '0;
                     state_in = S_GWALK;
                  end
                  default: begin
                     rsp_in.status = ST_BAD_ADDR;
                     state_in      = S_DONE;
                  end
               endcase
            end
         end

         // clearing pass, entry zero gets the whole managed range
         S_CLR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff[AW-1:0];
            ram_wdata = (clr_ff == '0) ? {cfg_blocks, {(LW + OW){1'b0}}} : '0;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == (AW + 1)'(BLOCK_SLOTS - 1)) begin
               state_in = S_IDLE;
            end
         end

         // best-fit walk over run heads
         S_AWALK: begin
            if (idx_ff >= n_ext) begin
               if (found_ff) begin
                  state_in = S_AGRANT;
               end else begin
                  rsp_in.status = ST_NO_MEM;
                  state_in      = S_DONE;
               end
            end else begin
               state_in = S_AEVAL;
            end
         end
         S_AEVAL: begin
            if (rd_free >= need_ff && (!found_ff || rd_free < best_free_ff)) begin
               best_in      = idx_ff[AW-1:0];
               best_free_in = rd_free;
               found_in     = 1'b1;
            end
            idx_in   = idx_ff + IW'(step);
            state_in = S_AWALK;
         end
         S_AGRANT: begin
            ram_we    = 1'b1;
            ram_waddr = best_ff;
            ram_wdata = {{LW{1'b0}}, need_ff, cl_ff};
            rsp_in.status          = ST_OK;
            rsp_in.granted_address = cfg_base + (32'(best_ff) << cfg_shift);
            rsp_in.granted_size    = 32'(need_ff) << cfg_shift;
            state_in = (need_ff < best_free_ff) ? S_ASPLIT : S_DONE;
         end
         S_ASPLIT: begin
            ram_we    = 1'b1;
            ram_waddr = best_ff + AW'(need_ff);
            ram_wdata = {best_free_ff - need_ff, {(LW + OW){1'b0}}};
            state_in  = S_DONE;
         end

         // release of one run head
         S_FHEAD: begin
            ram_raddr = head_ff;
            state_in  = S_FCHK;
         end
         S_FCHK: begin
            merged_in = 1'b0;
            if (rd_alloc == '0) begin
               rsp_in.status = ST_BAD_ADDR;
               state_in      = S_DONE;
            end else if (rd_owner != cl_ff) begin
               rsp_in.status = ST_NOT_OWN;
               state_in      = S_DONE;
            end else begin
               len_in = rd_alloc;
               fl_in  = rd_alloc;
               if (head_ext + IW'(rd_alloc) < n_ext) begin
                  state_in = S_RRD;
               end else if (head_ff == '0) begin
                  state_in = S_FWRITE;
               end else begin
                  idx_in   = head_ext - 1'b1;
                  state_in = S_LRD;
               end
            end
         end
         S_RRD: begin
            ram_raddr = right_idx[AW-1:0];
            state_in  = S_REV;
         end
         S_REV: begin
            if (rd_alloc == '0) begin
               fl_in     = fl_ff + rd_free;
               ram_we    = 1'b1;
               ram_waddr = right_idx[AW-1:0];
               ram_wdata = {{(2 * LW){1'b0}}, rd_owner};
            end
            if (head_ff == '0) begin
               state_in = S_FWRITE;
            end else begin
               idx_in   = head_ext - 1'b1;
               state_in = S_LRD;
            end
         end
         // leftward search for the previous run head, which absorbs the freed run if it is free
         S_LRD: begin
            state_in = S_LEV;
         end
         S_LEV: begin
            if (rd_free == '0 && rd_alloc == '0) begin
               if (idx_ff == '0) begin
                  state_in = S_FWRITE;
               end else begin
                  idx_in   = idx_ff - 1'b1;
                  state_in = S_LRD;
               end
            end else begin
               if (rd_free != '0) begin
                  ram_we    = 1'b1;
                  ram_waddr = idx_ff[AW-1:0];
                  ram_wdata = {rd_free + fl_ff, rd_alloc, rd_owner};
                  merged_in = 1'b1;
               end
               state_in = S_FWRITE;
            end
         end
         S_FWRITE: begin
            ram_we    = 1'b1;
            ram_waddr = head_ff;
            ram_wdata = {(merged_ff ? {LW{1'b0}} : fl_ff), {(LW + OW){1'b0}}};
            if (all_ff) begin
               idx_in   = right_idx;
               state_in = S_GWALK;
            end else begin
               rsp_in.status = ST_OK;
               state_in      = S_DONE;
            end
         end

         // free-all walk
         S_GWALK: begin
            if (idx_ff >= n_ext) begin
               rsp_in.status = ST_OK;
               state_in      = S_DONE;
            end else begin
               state_in = S_GEV;
            end
         end
         S_GEV: begin
            if (rd_alloc != '0 && rd_owner == cl_ff) begin
               head_in  = idx_ff[AW-1:0];
               state_in = S_FHEAD;
            end else begin
               idx_in   = idx_ff + IW'(step);
               state_in = S_GWALK;
            end
         end

         S_DONE: begin
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (reinit) begin
         clr_in   = '0;
         state_in = S_CLR;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      head_ff      <= head_in;
      best_ff      <= best_in;
      best_free_ff <= best_free_in;
      found_ff     <= found_in;
      need_ff      <= need_in;
      len_ff       <= len_in;
      fl_ff        <= fl_in;
      merged_ff    <= merged_in;
      cl_ff        <= cl_in;
      all_ff       <= all_in;
      rsp_ff       <= rsp_in;
   end

   `BFBA_ASSERT_NXT(a_accept_busy, start && !busy && !reinit, busy)
   `BFBA_ASSERT_IMP(a_rsp_idle, rsp_valid_ff, state_ff == S_IDLE)
   `BFBA_ASSERT_IMP(a_state_onehot, 1'b1, $onehot(state_ff))
   `BFBA_ASSERT_NXT(a_reinit_clear, reinit, state_ff == S_CLR)

endmodule

`default_nettype wire

### src/best_fit_block_allocator_unit.sv
// ----------------------------------------------------------------------------
// best_fit_block_allocator_unit
// best-fit block allocator with coalescing over a table of equal blocks
// ----------------------------------------------------------------------------
// usage:
//   an item is taken when start is high and busy is low; req_action selects
//   allocate, free of one region or free of every run a client owns
//   each item gives one result on the rsp_ ports, marked by rsp_valid for a
//   single cycle; the receiver cannot stall, so it must take it then
//   csr_ writes set base address, block shift and managed block count; a
//   count write rebuilds the table as one free run
//   each table entry read by the single ram read port takes a read state
//   and an evaluate state, besides setup and write-back states; an allocate
//   visits every run head, a free adds a leftward search that may reach
//   table entry zero, a free-all walks the table once and adds the work of
//   one free for each run it releases
//   one item at a time: busy stays high until its result is shown
//   reset and each count write start a clearing pass over every table entry
//   during which busy is high and no item is taken
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module best_fit_block_allocator_unit #(
   parameter int BLOCK_SLOTS = 256,
   parameter int CLIENT_BITS = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_action,
   input  wire logic [31:0] req_byte_count,
   input  wire logic [31:0] req_region_address,
   input  wire logic [7:0]  req_client_id,
   output logic             rsp_valid,
   output logic [1:0]       rsp_status,
   output logic [31:0]      rsp_granted_address,
   output logic [31:0]      rsp_granted_size,
   input  wire logic        csr_wr_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_wr_data
);
   import bfba_pkg::*;

   localparam int LW = $clog2(BLOCK_SLOTS + 1);

   logic [31:0]   base_ff;
   logic [4:0]    shift_ff;
   logic [LW-1:0] blocks_ff;
   logic          reinit;
   logic [8:0]    blk_raw;
   logic [LW-1:0] blk_clamped;
   rsp_type       rsp;

   // count write clamped to the managed range
   assign blk_raw = csr_wr_data[8:0];
   always_comb begin
      if (blk_raw == 9'd0) begin
         blk_clamped = LW'(1);
      end else if (32'(blk_raw) > BLOCK_SLOTS) begin
         blk_clamped = LW'(BLOCK_SLOTS);
      end else begin
         blk_clamped = LW'(blk_raw);
      end
   end

   assign reinit = csr_wr_en && (csr_index == REG_BLOCKS);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff   <= 32'd0;
         shift_ff  <= 5'd12;
         blocks_ff <= (BLOCK_SLOTS < 256) ? LW'(BLOCK_SLOTS) : LW'(256);
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_BASE: begin
               base_ff <= csr_wr_data;
            end
            REG_SHIFT: begin
               shift_ff <= (csr_wr_data[4:0] > MAX_SHIFT) ? MAX_SHIFT : csr_wr_data[4:0];
            end
            REG_BLOCKS: begin
               blocks_ff <= blk_clamped;
            end
            default: begin
               base_ff <= base_ff;
            end
         endcase
      end
   end

   bfba_core #(.BLOCK_SLOTS(BLOCK_SLOTS), .CLIENT_BITS(CLIENT_BITS)) u_core (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .action         (req_action),
      .byte_count     (req_byte_count),
      .region_address (req_region_address),
      .client_id      (req_client_id),
      .cfg_base       (base_ff),
      .cfg_shift      (shift_ff),
      .cfg_blocks     (blocks_ff),
      .reinit         (reinit),
      .rsp_valid      (rsp_valid),
      .rsp            (rsp)
   );

   // result fields
   assign rsp_status          = rsp.status;
   assign rsp_granted_address = rsp.granted_address;
   assign rsp_granted_size    = rsp.granted_size;

endmodule

`default_nettype wire
